// File: rtl/core/plist_pkg.sv
// Shared types, sizes and codes for the positional list core.
package plist_pkg;

  localparam int CAPACITY = 16;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CMP_W  = (FILL_W > POS_W) ? FILL_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             rot;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] fill;
    value_t           value;
  } cell_ctl_t;

endpackage

// File: rtl/core/plist_if.sv
// Command and result channel interfaces of the positional list core.
interface plist_req_if;
  logic                                valid;
  logic                                ready;
  logic [plist_pkg::CMD_W-1:0]         cmd;
  logic [plist_pkg::POS_W-1:0]         position;
  logic signed [plist_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface plist_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [plist_pkg::STATUS_W-1:0]       status;
  logic signed [plist_pkg::VALUE_W-1:0] element;
  logic [plist_pkg::COUNT_W-1:0]        count;
  logic                                 last;

  modport source (output valid, output status, output element, output count, output last,
                  input ready);
  modport sink   (input valid, input status, input element, input count, input last,
                  output ready);
endinterface

// File: rtl/core/plist_cell.sv
// One slot of the list chain: holds a value and trades it with its neighbors.
module plist_cell (
  input  logic                         clk,
  input  plist_pkg::cell_ctl_t         ctl,
  input  logic [plist_pkg::IDX_W-1:0]  idx,
  input  plist_pkg::value_t            left,
  input  plist_pkg::value_t            right,
  input  plist_pkg::value_t            head,
  output plist_pkg::value_t            q
);
  import plist_pkg::*;

  logic [CMP_W-1:0] idx_ext;
  logic [CMP_W-1:0] idx_inc;

  assign idx_ext = CMP_W'(idx);
  assign idx_inc = idx_ext + CMP_W'(1);

  // Insert: move up above the position, load at it.
  // Remove: move down from the position on.
  // Rotate: move down inside the filled part, tail takes the head.
  always_ff @(posedge clk) begin
    if (ctl.ins && idx_ext > ctl.pos) begin
      q <= left;
    end else if (ctl.ins && idx_ext == ctl.pos) begin
      q <= ctl.value;
    end else if (ctl.rem && idx_ext >= ctl.pos) begin
      q <= right;
    end else if (ctl.rot && idx_inc < ctl.fill) begin
      q <= right;
    end else if (ctl.rot && idx_inc == ctl.fill) begin
      q <= head;
    end
  end

endmodule

// File: rtl/core/positional_list_insert_remove_core.sv
// Top level of the positional list core: command decode, cell chain, result register.
//
// Usage:
//   req carries one command per beat (cmd, position, value); rsp carries result
//   beats (status, element, count, last). A beat moves when valid and ready are
//   both high at a rising edge of clk.
//   Append, insert and remove each give one status beat with last set; its count
//   is the element count after the command. The result is registered and shows
//   on rsp in the cycle after the command is accepted.
//   Dump of an empty list gives one beat with status empty. Otherwise the chain
//   rotates its filled part by one slot per beat and the head cell feeds rsp;
//   each rotate step after the command registers the head element, and one
//   element follows per cycle while rsp is not stalled; last marks the tail.
//   After the final beat the list is in its original order again.
//   Throughput: one append, insert or remove per cycle unless rsp stalls, since
//   every cell shifts in the same cycle; a dump keeps req not ready to its end.
//   A stall on rsp holds the result register and keeps req not ready; nothing
//   is dropped. Synchronous reset empties the list and clears rsp valid; slot
//   contents are left as they are and are never read before being written.
module positional_list_insert_remove_core (
  input  logic        clk,
  input  logic        rst,
  plist_req_if.sink   req,
  plist_rsp_if.source rsp
);
  import plist_pkg::*;

  // Element count and dump sequencing.
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              dumping;
  logic [FILL_W-1:0] dump_left;

  // Result register.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  value_t              out_element;
  logic [COUNT_W-1:0]  out_count;
  logic                out_last;

  logic             slot_free;
  logic             accept;
  logic             rot;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cmd_pos;
  logic             ins_ok;
  logic             rem_ok;
  logic [STATUS_W-1:0] cmd_status;
  cell_ctl_t        ctl;

  value_t slot_q [CAPACITY];

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = !dumping && slot_free;
  assign accept    = req.valid && req.ready;
  assign rot       = dumping && slot_free;

  assign fill_ext = CMP_W'(fill);
  assign pos_ext  = CMP_W'(req.position);

  // Decode the command: append is insert at the tail.
  always_comb begin
    cmd_pos    = pos_ext;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    cmd_status = ST_DONE;
    fill_next  = fill;
    unique case (req.cmd) inside
      CMD_APPEND, CMD_INSERT: begin
        if (req.cmd == CMD_APPEND) begin
          cmd_pos = fill_ext;
        end
        if (cmd_pos > fill_ext) begin
          cmd_status = ST_BADPOS;
        end else if (fill_ext >= CMP_W'(CAPACITY)) begin
          cmd_status = ST_FULL;
        end else begin
          ins_ok    = accept;
          fill_next = fill + FILL_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ext >= fill_ext) begin
          cmd_status = ST_BADPOS;
        end else begin
          rem_ok    = accept;
          fill_next = fill - FILL_W'(1);
        end
      end
      CMD_DUMP: begin
        cmd_status = ST_EMPTY;
      end
      default: begin
        cmd_status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    ctl.ins   = ins_ok;
    ctl.rem   = rem_ok;
    ctl.rot   = rot;
    ctl.pos   = cmd_pos;
    ctl.fill  = fill_ext;
    ctl.value = req.value;
  end

  // Chain of cells; the ends feed back their own value where no neighbor exists.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    plist_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .idx   (IDX_W'(i)),
      .left  (slot_q[(i == 0) ? 0 : i - 1]),
      .right (slot_q[(i == CAPACITY - 1) ? i : i + 1]),
      .head  (slot_q[0]),
      .q     (slot_q[i])
    );
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      dumping   <= 1'b0;
      dump_left <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept && req.cmd != CMD_DUMP) begin
        fill        <= fill_next;
        out_valid   <= 1'b1;
        out_status  <= cmd_status;
        out_element <= '0;
        out_count   <= COUNT_W'(fill_next);
        out_last    <= 1'b1;
      end else if (accept && fill == '0) begin
        out_valid   <= 1'b1;
        out_status  <= ST_EMPTY;
        out_element <= '0;
        out_count   <= '0;
        out_last    <= 1'b1;
      end else if (accept) begin
        // Hold req off and walk the list one beat at a time.
        dumping   <= 1'b1;
        dump_left <= fill;
        if (rsp.ready) begin
          out_valid <= 1'b0;
        end
      end else if (rot) begin
        out_valid   <= 1'b1;
        out_status  <= ST_DONE;
        out_element <= slot_q[0];
        out_count   <= COUNT_W'(fill);
        out_last    <= (dump_left == FILL_W'(1));
        dump_left   <= dump_left - FILL_W'(1);
        if (dump_left == FILL_W'(1)) begin
          dumping <= 1'b0;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.status  = out_status;
  assign rsp.element = out_element;
  assign rsp.count   = out_count;
  assign rsp.last    = out_last;

  // Checks on the sequencer.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_ext <= CMP_W'(CAPACITY))
    else $error("element count above capacity");

  a_dump_blocks: assert property (@(posedge clk) disable iff (rst)
    dumping |-> !req.ready && dump_left != '0)
    else $error("dump active with no elements left or req open");

  a_rot_emits: assert property (@(posedge clk) disable iff (rst)
    rot |=> out_valid && out_status == ST_DONE && $stable(fill))
    else $error("dump step gave no element beat");

  a_last_ends_dump: assert property (@(posedge clk) disable iff (rst)
    rot && dump_left == FILL_W'(1) |=> !dumping && out_last)
    else $error("final dump beat not marked last");

endmodule
